>>> sv/trex_pkg.sv
// Shared types, codes and constants of the timed execute stage.
package trex_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned ALU_FN_W   = 4;
  localparam int unsigned BR_KIND_W  = 3;
  localparam int unsigned OP_SEL_W   = 2;
  localparam int unsigned SHAMT_W    = 5;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [XLEN-1:0] NOP_VALUE      = 32'hDEAD_BEEF;
  localparam logic [XLEN-1:0] TIME_ADDR_BIAS = 32'd4;

  localparam logic [CFG_ADDR_W-1:0] ADDR_DATA_MEMORY_BASE = 2'd0;

  // Operand select bits.
  localparam int unsigned SEL_A_IS_PC  = 0;
  localparam int unsigned SEL_B_IS_IMM = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_NORMAL          = 3'd0,
    CMD_GET_TIME        = 3'd1,
    CMD_GET_TIMESTAMP   = 3'd2,
    CMD_LOAD_TIMESTAMP  = 3'd3,
    CMD_STORE_TIMESTAMP = 3'd4,
    CMD_DELAY           = 3'd5
  } cmd_t;

  typedef enum logic [ALU_FN_W-1:0] {
    ALU_ADD  = 4'd0,
    ALU_SUB  = 4'd1,
    ALU_AND  = 4'd2,
    ALU_OR   = 4'd3,
    ALU_XOR  = 4'd4,
    ALU_SLL  = 4'd5,
    ALU_SRA  = 4'd6,
    ALU_SRL  = 4'd7,
    ALU_LUI  = 4'd8,
    ALU_SLT  = 4'd9,
    ALU_SLTU = 4'd10,
    ALU_NOP  = 4'd11
  } alu_fn_t;

  typedef enum logic [BR_KIND_W-1:0] {
    BR_NONE = 3'd0,
    BR_JUMP = 3'd1,
    BR_EQ   = 3'd2,
    BR_NE   = 3'd3,
    BR_LT   = 3'd4,
    BR_LTU  = 3'd5,
    BR_GE   = 3'd6,
    BR_GEU  = 3'd7
  } br_kind_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [ALU_FN_W-1:0]  alu_function;
    logic [BR_KIND_W-1:0] branch_kind;
    logic [OP_SEL_W-1:0]  operand_select;
    logic [XLEN-1:0]      source_a;
    logic [XLEN-1:0]      source_b;
    logic [XLEN-1:0]      source_c;
    logic [XLEN-1:0]      instr_pc;
    logic [XLEN-1:0]      immediate;
    logic [XLEN-1:0]      time_now;
    logic [XLEN-1:0]      loaded_word;
  } in_beat_t;

  typedef struct packed {
    logic [XLEN-1:0] result_value;
    logic            branch_taken;
    logic            stall_res;
    logic [XLEN-1:0] mem_offset;
    logic            mem_write_enable;
    logic [XLEN-1:0] mem_write_data;
    logic [XLEN-1:0] store_forward;
    logic [XLEN-1:0] timestamp_out;
  } out_beat_t;

  typedef struct packed {
    logic [ALU_FN_W-1:0] fn;
    logic [XLEN-1:0]     a;
    logic [XLEN-1:0]     b;
  } alu_req_t;

  typedef struct packed {
    logic [BR_KIND_W-1:0] kind;
    logic [XLEN-1:0]      a;
    logic [XLEN-1:0]      b;
  } br_req_t;

endpackage

>>> sv/trex_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
interface trex_in_if;
  logic                             valid;
  logic                             ready;
  logic [trex_pkg::CMD_W-1:0]       command;
  logic [trex_pkg::ALU_FN_W-1:0]    alu_function;
  logic [trex_pkg::BR_KIND_W-1:0]   branch_kind;
  logic [trex_pkg::OP_SEL_W-1:0]    operand_select;
  logic [trex_pkg::XLEN-1:0]        source_a;
  logic [trex_pkg::XLEN-1:0]        source_b;
  logic [trex_pkg::XLEN-1:0]        source_c;
  logic [trex_pkg::XLEN-1:0]        instr_pc;
  logic [trex_pkg::XLEN-1:0]        immediate;
  logic [trex_pkg::XLEN-1:0]        time_now;
  logic [trex_pkg::XLEN-1:0]        loaded_word;

  modport source (
    output valid, command, alu_function, branch_kind, operand_select,
           source_a, source_b, source_c, instr_pc, immediate, time_now, loaded_word,
    input  ready
  );
  modport sink (
    input  valid, command, alu_function, branch_kind, operand_select,
           source_a, source_b, source_c, instr_pc, immediate, time_now, loaded_word,
    output ready
  );
endinterface

interface trex_out_if;
  logic                      valid;
  logic                      ready;
  logic [trex_pkg::XLEN-1:0] result_value;
  logic                      branch_taken;
  logic                      stall_res;
  logic [trex_pkg::XLEN-1:0] mem_offset;
  logic                      mem_write_enable;
  logic [trex_pkg::XLEN-1:0] mem_write_data;
  logic [trex_pkg::XLEN-1:0] store_forward;
  logic [trex_pkg::XLEN-1:0] timestamp_out;

  modport source (
    output valid, result_value, branch_taken, stall_res, mem_offset,
           mem_write_enable, mem_write_data, store_forward, timestamp_out,
    input  ready
  );
  modport sink (
    input  valid, result_value, branch_taken, stall_res, mem_offset,
           mem_write_enable, mem_write_data, store_forward, timestamp_out,
    output ready
  );
endinterface

>>> sv/trex_alu.sv
// Twelve-function integer ALU.
module trex_alu (
  input  trex_pkg::alu_req_t           req,
  output logic [trex_pkg::XLEN-1:0]    result
);
  import trex_pkg::*;

  logic [SHAMT_W-1:0] sh;

  assign sh = req.b[SHAMT_W-1:0];

  always_comb begin
    case (req.fn)
      ALU_ADD:  result = req.a + req.b;
      ALU_SUB:  result = req.a - req.b;
      ALU_AND:  result = req.a & req.b;
      ALU_OR:   result = req.a | req.b;
      ALU_XOR:  result = req.a ^ req.b;
      ALU_SLL:  result = req.a << sh;
      ALU_SRA:  result = XLEN'($signed(req.a) >>> sh);
      ALU_SRL:  result = req.a >> sh;
      ALU_LUI:  result = req.b;
      ALU_SLT:  result = {{(XLEN-1){1'b0}}, ($signed(req.a) < $signed(req.b))};
      ALU_SLTU: result = {{(XLEN-1){1'b0}}, (req.a < req.b)};
      default:  result = NOP_VALUE;
    endcase
  end
endmodule

>>> sv/trex_branch.sv
// Branch condition evaluation on the two register operands.
module trex_branch (
  input  trex_pkg::br_req_t req,
  output logic              cond
);
  import trex_pkg::*;

  logic eq;
  logic lt_s;
  logic lt_u;

  assign eq   = (req.a == req.b);
  assign lt_s = ($signed(req.a) < $signed(req.b));
  assign lt_u = (req.a < req.b);

  always_comb begin
    case (req.kind)
      BR_JUMP: cond = 1'b1;
      BR_EQ:   cond = eq;
      BR_NE:   cond = !eq;
      BR_LT:   cond = lt_s;
      BR_LTU:  cond = lt_u;
      BR_GE:   cond = !lt_s;
      BR_GEU:  cond = !lt_u;
      default: cond = 1'b0;
    endcase
  end
endmodule

>>> sv/trex_cfg.sv
// APB register file holding the data memory base address.
module trex_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [trex_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [trex_pkg::XLEN-1:0]           pwdata,
  output logic [trex_pkg::XLEN-1:0]           prdata,
  output logic                                pready,
  output logic [trex_pkg::XLEN-1:0]           data_memory_base
);
  import trex_pkg::*;

  logic [XLEN-1:0] base_r;
  logic [XLEN-1:0] base_nxt;
  logic            wr_base;

  assign pready  = 1'b1;
  assign wr_base = psel && penable && pwrite && (paddr == ADDR_DATA_MEMORY_BASE);
  assign base_nxt = wr_base ? pwdata : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else begin
      base_r <= base_nxt;
    end
  end

  always_comb begin
    case (paddr)
      ADDR_DATA_MEMORY_BASE: prdata = base_r;
      default:               prdata = '0;
    endcase
  end

  assign data_memory_base = base_r;
endmodule

>>> sv/timed_risc_execute_stage_top.sv
// Top level of the timed execute stage: input register, execute logic, result register.
//
//   channel | direction | handshake      | payload
//   --------+-----------+----------------+-------------------------------------------
//   in_if   | sink      | valid/ready    | decoded instruction, operands, time, word
//   out_if  | source    | valid/ready    | ALU/branch result, stall, time memory ctl
//   APB     | slave     | psel/penable   | data_memory_base at byte address 0
//
// One beat per cycle sustained while out_if.ready holds; an accepted beat passes the
// input register, then the result register, before the result is valid.
// Reset (rst_n low, synchronous) empties both registers and clears the stored
// timestamp and the base register.
// A stalled result stage holds its beat; the input register keeps accepting as long
// as its own beat can move forward in the same cycle.
module timed_risc_execute_stage_top (
  input  logic                              clk,
  input  logic                              rst_n,
  trex_in_if.sink                           in_if,
  trex_out_if.source                        out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [trex_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [trex_pkg::XLEN-1:0]         pwdata,
  output logic [trex_pkg::XLEN-1:0]         prdata,
  output logic                              pready
);
  import trex_pkg::*;

  // Pipeline control and state.
  logic            in_vld_r,  in_vld_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic [XLEN-1:0] ts_r,      ts_nxt;
  in_beat_t        in_beat_r;
  out_beat_t       out_beat_r, out_beat_nxt;

  logic            in_take;
  logic            adv;
  logic [XLEN-1:0] base;

  // Execute-pass signals.
  alu_req_t        alu_req;
  br_req_t         br_req;
  logic [XLEN-1:0] alu_res;
  logic            br_cond;
  logic            timed;
  logic            stall;
  logic            is_load;
  logic            is_store;
  logic            ld_ok;

  trex_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .data_memory_base (base)
  );

  // Advance the input beat when the result register is empty or draining.
  assign adv         = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || adv;
  assign in_take     = in_if.valid && in_if.ready;

  // Operand muxes: pc or source_a first, immediate or source_b second.
  assign alu_req.fn = in_beat_r.alu_function;
  assign alu_req.a  = in_beat_r.operand_select[SEL_A_IS_PC]  ? in_beat_r.instr_pc
                                                              : in_beat_r.source_a;
  assign alu_req.b  = in_beat_r.operand_select[SEL_B_IS_IMM] ? in_beat_r.immediate
                                                              : in_beat_r.source_b;

  // Branches always compare the raw register operands.
  assign br_req.kind = in_beat_r.branch_kind;
  assign br_req.a    = in_beat_r.source_a;
  assign br_req.b    = in_beat_r.source_b;

  trex_alu u_alu (
    .req    (alu_req),
    .result (alu_res)
  );

  trex_branch u_branch (
    .req  (br_req),
    .cond (br_cond)
  );

  // Load, store and delay wait while source_a lies later than the timer.
  assign is_load  = (in_beat_r.command == CMD_LOAD_TIMESTAMP);
  assign is_store = (in_beat_r.command == CMD_STORE_TIMESTAMP);
  assign timed    = is_load || is_store || (in_beat_r.command == CMD_DELAY);
  assign stall    = timed && (in_beat_r.source_a > in_beat_r.time_now);
  assign ld_ok    = is_load && !stall;

  always_comb begin
    // Unused command codes fall through to the ALU like a normal instruction.
    case (in_beat_r.command)
      CMD_GET_TIME:        out_beat_nxt.result_value = in_beat_r.time_now;
      CMD_GET_TIMESTAMP:   out_beat_nxt.result_value = ts_r;
      CMD_LOAD_TIMESTAMP,
      CMD_STORE_TIMESTAMP: out_beat_nxt.result_value = in_beat_r.source_b;
      default:             out_beat_nxt.result_value = alu_res;
    endcase
    out_beat_nxt.branch_taken     = br_cond && !stall;
    out_beat_nxt.stall_res        = stall;
    out_beat_nxt.mem_offset       = in_beat_r.source_b + TIME_ADDR_BIAS - base;
    out_beat_nxt.mem_write_enable = is_store && !stall;
    out_beat_nxt.mem_write_data   = (is_store && !stall) ? in_beat_r.source_a : '0;
    out_beat_nxt.store_forward    = is_store ? in_beat_r.source_c : in_beat_r.source_b;
    out_beat_nxt.timestamp_out    = ld_ok ? in_beat_r.loaded_word : ts_r;
  end

  // Update the timestamp only when the beat actually moves forward.
  assign ts_nxt      = (adv && ld_ok) ? in_beat_r.loaded_word : ts_r;
  assign in_vld_nxt  = in_take ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_if.ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ts_r      <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      ts_r      <= ts_nxt;
    end
  end

  // Payload registers: the input beat captures on accept, the result beat on advance; both hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_beat_r.command        <= in_if.command;
      in_beat_r.alu_function   <= in_if.alu_function;
      in_beat_r.branch_kind    <= in_if.branch_kind;
      in_beat_r.operand_select <= in_if.operand_select;
      in_beat_r.source_a       <= in_if.source_a;
      in_beat_r.source_b       <= in_if.source_b;
      in_beat_r.source_c       <= in_if.source_c;
      in_beat_r.instr_pc       <= in_if.instr_pc;
      in_beat_r.immediate      <= in_if.immediate;
      in_beat_r.time_now       <= in_if.time_now;
      in_beat_r.loaded_word    <= in_if.loaded_word;
    end
    if (adv) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_if.valid            = out_vld_r;
  assign out_if.result_value     = out_beat_r.result_value;
  assign out_if.branch_taken     = out_beat_r.branch_taken;
  assign out_if.stall_res        = out_beat_r.stall_res;
  assign out_if.mem_offset       = out_beat_r.mem_offset;
  assign out_if.mem_write_enable = out_beat_r.mem_write_enable;
  assign out_if.mem_write_data   = out_beat_r.mem_write_data;
  assign out_if.store_forward    = out_beat_r.store_forward;
  assign out_if.timestamp_out    = out_beat_r.timestamp_out;

  // A blocked input beat must stay in place.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r)
    else $error("input beat dropped while result stage was blocked");

  // A stalled step leaves the stored timestamp untouched.
  a_stall_keeps_ts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && stall |=> ts_r == $past(ts_r))
    else $error("stalled step changed the stored timestamp");

  // A completed timestamp load shows up in the state in the next cycle.
  a_load_ts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ld_ok |=> ts_r == $past(in_beat_r.loaded_word))
    else $error("timestamp load not taken");

  // A stalled result never writes memory or takes a branch.
  a_stall_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_beat_r.stall_res |-> !out_beat_r.mem_write_enable
                                         && !out_beat_r.branch_taken)
    else $error("stalled result carries side effects");

endmodule
